// ===== design/bma_pkg.sv =====
package bma_pkg;

  // Field widths of the request and response words.
  localparam int FUNC_W   = 1;
  localparam int SIZE_W   = 11;
  localparam int CHUNK_W  = 8;
  localparam int STATUS_W = 2;
  localparam int BYTE_W   = 10;
  localparam int MERGE_W  = 3;

  // Request function codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADSIZE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADCHUNK = 2'd3;

endpackage

// ===== design/bma_req_if.sv =====
interface bma_req_if import bma_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [SIZE_W-1:0]  request_size;
  logic [CHUNK_W-1:0] chunk_index;

  modport source (output valid, output func, output request_size, output chunk_index,
                  input ready);
  modport sink   (input valid, input func, input request_size, input chunk_index,
                  output ready);

endinterface

// ===== design/bma_rsp_if.sv =====
interface bma_rsp_if import bma_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CHUNK_W-1:0]  chunk_number;
  logic [BYTE_W-1:0]   start_byte;
  logic [BYTE_W-1:0]   end_byte;
  logic [MERGE_W-1:0]  merge_count;

  modport source (output valid, output status, output chunk_number, output start_byte,
                  output end_byte, output merge_count, input ready);
  modport sink   (input valid, input status, input chunk_number, input start_byte,
                  input end_byte, input merge_count, output ready);

endinterface

// ===== design/bma_ffs.sv =====
module bma_ffs #(
  parameter int W = 128
) (
  input  logic [W-1:0]         row,
  output logic                 found,
  output logic [$clog2(W)-1:0] pos
);

  localparam int STEPS = $clog2(W);

  logic [W-1:0] v;

  // Binary search for the lowest set bit: at each step, if the lower half
  // of what remains is empty, the answer lies in the upper half.
  always_comb begin
    v   = row;
    pos = '0;
    for (int k = STEPS - 1; k >= 0; k--) begin
      if ((v & ({W{1'b1}} >> (W - (1 << k)))) == '0) begin
        v      = v >> (1 << k);
        pos[k] = 1'b1;
      end
    end
  end

  assign found = |row;

endmodule

// ===== design/buddy_memory_allocator.sv =====
// Buddy allocator over 2^(MIN_BLOCK_LOG2+LEVELS-1) bytes, one word at a time.
// Allocate: search up from the requested level for a free chunk, then split it
// down to that level (none up to the top level answers no-memory). Free: check
// the chunk, then merge while its buddy is free. A bad size skips to the result.
// The walk reads one free-map row per cycle through a single priority encoder.
// Synchronous reset leaves only the single top-level chunk free.
module buddy_memory_allocator import bma_pkg::*; #(
  parameter int LEVELS         = 8,
  parameter int MIN_BLOCK_LOG2 = 3
) (
  input logic       clk,
  input logic       rst,
  bma_req_if.sink   req,
  bma_rsp_if.source rsp
);

  localparam int MAX_CHUNKS = 1 << (LEVELS - 1);
  localparam int IDX_W      = LEVELS - 1;
  localparam int LVL_W      = $clog2(LEVELS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_SPLIT  = 6'b000100,
    S_CHECK  = 6'b001000,
    S_MERGE  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state;

  logic [MAX_CHUNKS-1:0] free_map [LEVELS];

  logic [LVL_W-1:0]    lvl;
  logic [LVL_W-1:0]    up;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    cur;
  logic [LVL_W-1:0]    mcount;
  logic [CHUNK_W-1:0]  chunk;
  logic [STATUS_W-1:0] status;

  logic               size_ok;
  logic [LVL_W-1:0]   size_lvl;
  logic               ffs_found;
  logic [IDX_W-1:0]   ffs_pos;
  logic [LVL_W-1:0]   up_inc;
  logic [LVL_W-1:0]   up_dec;
  logic               up_last;
  logic [IDX_W-1:0]   idx_dbl;
  logic [IDX_W-1:0]   buddy;
  logic [31:0]        chunk_dec;
  logic [IDX_W-1:0]   chunk_idx;
  logic               chunk_bad;
  logic               res_ok;
  logic [31:0]        start_w;
  logic [31:0]        end_w;
  logic [31:0]        num_w;
  logic [31:0]        merge_w;

  // Level of the requested size: the smallest block that holds it.
  always_comb begin
    size_ok  = 1'b0;
    size_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (req.request_size != '0 &&
          (32'd1 << (MIN_BLOCK_LOG2 + l)) >= 32'(req.request_size)) begin
        size_ok  = 1'b1;
        size_lvl = LVL_W'(l);
      end
    end
  end

  bma_ffs #(.W(MAX_CHUNKS)) u_ffs (
    .row   (free_map[up]),
    .found (ffs_found),
    .pos   (ffs_pos)
  );

  assign up_inc    = up + 1'b1;
  assign up_dec    = up - 1'b1;
  assign up_last   = (up == LVL_W'(LEVELS - 1));
  assign idx_dbl   = idx << 1;
  assign buddy     = cur ^ IDX_W'(1);
  assign chunk_dec = 32'(chunk) - 32'd1;
  assign chunk_idx = chunk_dec[IDX_W-1:0];
  assign chunk_bad = (chunk == '0) ||
                     (32'(chunk) > (32'd1 << (LEVELS - 1 - 32'(lvl))));

  // Response fields; every field but the status reads zero on an error.
  assign res_ok  = (status == ST_OK);
  assign start_w = res_ok ? (32'(idx) << (32'(MIN_BLOCK_LOG2) + 32'(lvl))) : 32'd0;
  assign end_w   = res_ok ?
                   (start_w + (32'd1 << (32'(MIN_BLOCK_LOG2) + 32'(lvl))) - 32'd1) : 32'd0;
  assign num_w   = res_ok ? (32'(idx) + 32'd1) : 32'd0;
  assign merge_w = res_ok ? 32'(mcount) : 32'd0;

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      for (int r = 0; r < LEVELS; r++) begin
        free_map[r] <= (r == LEVELS - 1) ? MAX_CHUNKS'(1) : '0;
      end
    end else begin
      // In the result state the response register is handled below.
      if (rsp.valid && rsp.ready && state != S_RESULT) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            lvl    <= size_lvl;
            up     <= size_lvl;
            chunk  <= req.chunk_index;
            mcount <= '0;
            if (!size_ok) begin
              status <= ST_BADSIZE;
              state  <= S_RESULT;
            end else if (req.func == FUNC_ALLOC) begin
              state <= S_SEARCH;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_SEARCH: begin
          if (ffs_found) begin
            free_map[up][ffs_pos] <= 1'b0;
            idx <= ffs_pos;
            if (up == lvl) begin
              status <= ST_OK;
              state  <= S_RESULT;
            end else begin
              state <= S_SPLIT;
            end
          end else if (up_last) begin
            status <= ST_NOMEM;
            state  <= S_RESULT;
          end else begin
            up <= up_inc;
          end
        end
        S_SPLIT: begin
          // The lower half goes on down; the upper half stays free.
          free_map[up_dec][idx_dbl | IDX_W'(1)] <= 1'b1;
          idx <= idx_dbl;
          up  <= up_dec;
          if (up_dec == lvl) begin
            status <= ST_OK;
            state  <= S_RESULT;
          end
        end
        S_CHECK: begin
          if (chunk_bad || free_map[lvl][chunk_idx]) begin
            status <= ST_BADCHUNK;
            state  <= S_RESULT;
          end else begin
            free_map[lvl][chunk_idx] <= 1'b1;
            idx   <= chunk_idx;
            cur   <= chunk_idx;
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (!up_last && free_map[up][buddy]) begin
            free_map[up][cur]            <= 1'b0;
            free_map[up][buddy]          <= 1'b0;
            free_map[up_inc][cur >> 1]   <= 1'b1;
            cur    <= cur >> 1;
            up     <= up_inc;
            mcount <= mcount + 1'b1;
          end else begin
            status <= ST_OK;
            state  <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= status;
            rsp.chunk_number <= num_w[CHUNK_W-1:0];
            rsp.start_byte   <= start_w[BYTE_W-1:0];
            rsp.end_byte     <= end_w[BYTE_W-1:0];
            rsp.merge_count  <= merge_w[MERGE_W-1:0];
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A failed request leaves every field but the status at zero.
  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |->
      rsp.chunk_number == '0 && rsp.start_byte == '0 && rsp.end_byte == '0 &&
      rsp.merge_count == '0)
    else $error("error response carries non-zero fields");

  // The whole memory is a single chunk, so no other top-level bit can be free.
  a_top_row_single: assert property (@(posedge clk) disable iff (rst)
    free_map[LEVELS-1][MAX_CHUNKS-1:1] == '0)
    else $error("spurious free chunk at the top level");

  // Once a word is taken the sequencer is not ready in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted on consecutive cycles");

endmodule

// ===== bench/bma_checker.sv =====
module bma_checker import bma_pkg::*; #(
  parameter int LEVELS         = 8,
  parameter int MIN_BLOCK_LOG2 = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_ready,
  input  logic [FUNC_W-1:0]   req_func,
  input  logic [SIZE_W-1:0]   req_size,
  input  logic [CHUNK_W-1:0]  req_chunk,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  logic [STATUS_W-1:0] rsp_status,
  input  logic [CHUNK_W-1:0]  rsp_chunk_number,
  input  logic [BYTE_W-1:0]   rsp_start_byte,
  input  logic [BYTE_W-1:0]   rsp_end_byte,
  input  logic [MERGE_W-1:0]  rsp_merge_count,
  output int                  fail_count,
  output int                  pending
);

  localparam int MAX_CHUNKS = 1 << (LEVELS - 1);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CHUNK_W-1:0]  chunk_number;
    logic [BYTE_W-1:0]   start_byte;
    logic [BYTE_W-1:0]   end_byte;
    logic [MERGE_W-1:0]  merge_count;
  } alloc_word_t;

  // One free bit per chunk and level, kept in step with the block.
  logic [MAX_CHUNKS-1:0] chunk_free [LEVELS];
  alloc_word_t           awaited_words [$];
  int                    words_seen;

  initial begin
    fail_count = 0;
    pending    = 0;
    words_seen = 0;
  end

  function automatic int chunks_at(int lvl);
    return 1 << (LEVELS - 1 - lvl);
  endfunction

  function automatic int lowest_free(int lvl);
    for (int i = 0; i < chunks_at(lvl); i++) begin
      if (chunk_free[lvl][i]) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int size_to_level(logic [SIZE_W-1:0] size);
    int lvl;
    lvl = -1;
    if (size != 0) begin
      for (int l = 0; l < LEVELS; l++) begin
        if (lvl < 0 && (1 << (MIN_BLOCK_LOG2 + l)) >= size) begin
          lvl = l;
        end
      end
    end
    return lvl;
  endfunction

  function automatic alloc_word_t error_word(logic [STATUS_W-1:0] code);
    alloc_word_t w;
    w        = '0;
    w.status = code;
    return w;
  endfunction

  function automatic alloc_word_t block_word(int lvl, int idx, int merges);
    alloc_word_t w;
    int          sh;
    int          first;
    sh             = MIN_BLOCK_LOG2 + lvl;
    first          = idx << sh;
    w.status       = ST_OK;
    w.chunk_number = CHUNK_W'(idx + 1);
    w.start_byte   = BYTE_W'(first);
    w.end_byte     = BYTE_W'(first + (1 << sh) - 1);
    w.merge_count  = MERGE_W'(merges);
    return w;
  endfunction

  function automatic alloc_word_t predict_word(logic [FUNC_W-1:0] func,
                                               logic [SIZE_W-1:0] size,
                                               logic [CHUNK_W-1:0] chunk);
    int lvl;
    int up;
    int idx;
    int cur;
    int merges;
    lvl = size_to_level(size);
    if (lvl < 0) begin
      return error_word(ST_BADSIZE);
    end
    if (func == FUNC_ALLOC) begin
      up  = lvl;
      idx = -1;
      while (idx < 0 && up < LEVELS) begin
        idx = lowest_free(up);
        if (idx < 0) begin
          up++;
        end
      end
      if (idx < 0) begin
        return error_word(ST_NOMEM);
      end
      chunk_free[up][idx] = 1'b0;
      // Split down: the upper half of each split stays free.
      while (up > lvl) begin
        up--;
        idx = idx << 1;
        chunk_free[up][idx + 1] = 1'b1;
      end
      return block_word(lvl, idx, 0);
    end
    if (chunk == 0 || chunk > chunks_at(lvl)) begin
      return error_word(ST_BADCHUNK);
    end
    idx = chunk - 1;
    // Only the bit of the requested level decides whether it is already free.
    if (chunk_free[lvl][idx]) begin
      return error_word(ST_BADCHUNK);
    end
    chunk_free[lvl][idx] = 1'b1;
    cur    = idx;
    up     = lvl;
    merges = 0;
    while (up + 1 < LEVELS && chunk_free[up][cur ^ 1]) begin
      chunk_free[up][cur]     = 1'b0;
      chunk_free[up][cur ^ 1] = 1'b0;
      cur = cur >> 1;
      up++;
      chunk_free[up][cur] = 1'b1;
      merges++;
    end
    return block_word(lvl, idx, merges);
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] response word %0d: %s", $realtime, words_seen, what);
    fail_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("%s is %0d, should be %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        chunk_free[l] = '0;
      end
      chunk_free[LEVELS-1][0] = 1'b1;
      awaited_words.delete();
    end else begin
      // The new request is queued first; its answer is always behind any older one.
      if (req_valid && req_ready) begin
        awaited_words.push_back(predict_word(req_func, req_size, req_chunk));
      end
      if (rsp_valid && rsp_ready) begin
        words_seen++;
        if (awaited_words.size() == 0) begin
          report_mismatch("arrived with no request outstanding");
        end else begin
          check_field("status", rsp_status, awaited_words[0].status);
          check_field("chunk_number", rsp_chunk_number, awaited_words[0].chunk_number);
          check_field("start_byte", rsp_start_byte, awaited_words[0].start_byte);
          check_field("end_byte", rsp_end_byte, awaited_words[0].end_byte);
          check_field("merge_count", rsp_merge_count, awaited_words[0].merge_count);
          void'(awaited_words.pop_front());
        end
      end
    end
    pending <= awaited_words.size();
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import bma_pkg::*;

  localparam int LEVELS         = 8;
  localparam int MIN_BLOCK_LOG2 = 3;
  localparam int RANDOM_WORDS   = 1350;
  localparam int STALL_LIMIT    = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bma_req_if req_ch ();
  bma_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int stall_cycles = 0;
  bit calm = 1'b0;

  // Functions of accepted requests, oldest first, and the blocks held at present.
  logic [FUNC_W-1:0] funcs_in_flight [$];
  logic [FUNC_W-1:0] answered_func;
  int                held_bytes [$];
  int                held_chunk [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  buddy_memory_allocator #(
    .LEVELS         (LEVELS),
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bma_checker #(
    .LEVELS         (LEVELS),
    .MIN_BLOCK_LOG2 (MIN_BLOCK_LOG2)
  ) chk (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_ch.valid),
    .req_ready        (req_ch.ready),
    .req_func         (req_ch.func),
    .req_size         (req_ch.request_size),
    .req_chunk        (req_ch.chunk_index),
    .rsp_valid        (rsp_ch.valid),
    .rsp_ready        (rsp_ch.ready),
    .rsp_status       (rsp_ch.status),
    .rsp_chunk_number (rsp_ch.chunk_number),
    .rsp_start_byte   (rsp_ch.start_byte),
    .rsp_end_byte     (rsp_ch.end_byte),
    .rsp_merge_count  (rsp_ch.merge_count),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always @(negedge clk) begin
    rsp_ch.ready = calm || ($urandom_range(0, 99) >= 38);
  end

  // Successful allocations become blocks that later requests may free.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && funcs_in_flight.size() > 0) begin
      answered_func = funcs_in_flight.pop_front();
      if (answered_func == FUNC_ALLOC && rsp_ch.status == ST_OK) begin
        held_bytes.push_back(int'(rsp_ch.end_byte) - int'(rsp_ch.start_byte) + 1);
        held_chunk.push_back(int'(rsp_ch.chunk_number));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  task automatic send_word(input logic [FUNC_W-1:0] func, input int size, input int chunk);
    bit placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < 38) begin
        req_ch.valid = 1'b0;
      end else begin
        req_ch.valid        = 1'b1;
        req_ch.func         = func;
        req_ch.request_size = SIZE_W'(size);
        req_ch.chunk_index  = CHUNK_W'(chunk);
        placed              = 1'b1;
      end
    end
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    funcs_in_flight.push_back(func);
  endtask

  task automatic alloc_word(input int size);
    send_word(FUNC_ALLOC, size, $urandom_range(0, 255));
  endtask

  task automatic free_word(input int size, input int chunk);
    send_word(FUNC_FREE, size, chunk);
  endtask

  task automatic drain_responses();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return $urandom_range(1, 16);
    end else if (roll < 85) begin
      return $urandom_range(17, 128);
    end else if (roll < 97) begin
      return $urandom_range(129, 512);
    end
    return $urandom_range(513, 1024);
  endfunction

  initial begin
    int n;
    int roll;
    int k;
    int bytes;
    int chunk;
    int lvl;
    int bias;
    req_ch.valid        = 1'b0;
    req_ch.func         = FUNC_ALLOC;
    req_ch.request_size = '0;
    req_ch.chunk_index  = '0;
    rsp_ch.ready        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    alloc_word(1024);
    alloc_word(1);
    alloc_word(0);
    alloc_word(1025);
    free_word(2047, 255);
    // A chunk that was never marked free at the smallest level is taken back.
    free_word(8, 128);
    alloc_word(8);
    free_word(1024, 1);
    free_word(1024, 1);
    free_word(512, 3);
    free_word(8, 0);
    alloc_word(3);
    alloc_word(8);
    alloc_word(16);
    free_word(8, 1);
    free_word(8, 1);
    free_word(16, 2);
    // Every other chunk is free now, so this one merges all the way up.
    free_word(8, 2);
    alloc_word(600);
    alloc_word(512);
    free_word(1024, 1);
    drain_responses();

    for (n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 500 && n < 800);
      if (n % 300 == 150) begin
        drain_responses();
      end
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        send_word(FUNC_W'($urandom_range(0, 1)), $urandom_range(0, 2047),
                  $urandom_range(0, 255));
      end else if (roll < 17) begin
        lvl = $urandom_range(0, LEVELS - 1);
        chunk = $urandom_range(0, 1) ? 0
              : (1 << (LEVELS - 1 - lvl)) + $urandom_range(1, 3);
        free_word(1 << (MIN_BLOCK_LOG2 + lvl), chunk);
      end else begin
        bias = (held_chunk.size() > 24) ? 70 : (held_chunk.size() > 6) ? 45 : 20;
        if (held_chunk.size() > 0 && $urandom_range(0, 99) < bias) begin
          k     = $urandom_range(0, held_chunk.size() - 1);
          bytes = held_bytes[k];
          chunk = held_chunk[k];
          held_bytes.delete(k);
          held_chunk.delete(k);
          free_word((bytes == 8) ? $urandom_range(1, 8) : $urandom_range(bytes / 2 + 1, bytes),
                    chunk);
        end else begin
          alloc_word(pick_size());
        end
      end
    end
    calm = 1'b0;

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
